// ----- rtl/rma_pkg.sv -----
// Shared types and constants of the ranking metric accumulator.
// Holds command, status and divider-select codes, the control/status
// structs and the discount table function. Depends on nothing.
package rma_pkg;

  localparam int DISC_W = 17;
  localparam int FRAC_W = 16;
  localparam int CNT_W  = 32;
  localparam int SUM_W  = 48;
  localparam int DIV_NW = 48;
  localparam int DIV_DW = 32;
  localparam int ITEM_W = 12;

  typedef enum logic [1:0] {
    CMD_TRUTH = 2'd0,
    CMD_REC   = 2'd1,
    CMD_END   = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DUP     = 2'd1,
    ST_DROP    = 2'd2,
    ST_COUNTED = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    DS_HIT,
    DS_REC,
    DS_PRE,
    DS_NDCG,
    DS_MAP
  } dsel_e;

  typedef struct packed {
    logic  accept;
    logic  exec;
    logic  walk_start;
    logic  walk_step;
    logic  div_start;
    dsel_e div_sel;
    logic  user_clear;
    logic  out_load;
    logic  clr_step;
  } ctl_t;

  typedef struct packed {
    logic clr_done;
    cmd_e cmd;
    logic hit_fire;
    logic empty_user;
    logic walk_end;
    logic div_done;
  } sts_t;

  // Q1.16 of 1/log2(n), log2 in Q.30 by repeated squaring, rounded half up.
  // Only evaluated at elaboration.
  function automatic logic [DISC_W-1:0] disc_calc(input int unsigned n);
    logic [63:0] x;
    logic [63:0] frac;
    logic [63:0] lq;
    logic [63:0] num;
    logic [63:0] rem;
    logic [63:0] q;
    int unsigned k;
    k = 0;
    for (int i = 0; i < 31; i++) begin
      if ((n >> (i + 1)) != 0) k = i + 1;
    end
    x = (64'(n) << 30) >> k;
    frac = 64'd0;
    for (int b = 0; b < 30; b++) begin
      x = (x * x) >> 30;
      frac = frac << 1;
      if (x >= 64'h8000_0000) begin
        x = x >> 1;
        frac = frac | 64'd1;
      end
    end
    lq = (64'(k) << 30) | frac;
    num = (64'd1 << 46) + (lq >> 1);
    rem = 64'd0;
    q = 64'd0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= lq) begin
        rem = rem - lq;
        q[i] = 1'b1;
      end
    end
    return q[DISC_W-1:0];
  endfunction

endpackage

// ----- rtl/ranking_metric_accumulator.sv -----
// Ranking metric accumulator: recall, precision, NDCG and MAP sums per user.
// Input channel (valid/stall) carries cmd and item; each transaction gives
// exactly one result transaction on the output channel with all running
// totals and sums, the item counter for a read, and a status code.
// Ground-truth, drop, read and miss transactions go from acceptance through
// an execute step to the output register. A hit runs one division in the
// serial divider, 48 quotient bits at one bit a cycle. End of user walks
// the truth list, one entry a cycle, then runs four divisions unless the
// user has no truths or no recommendations. One transaction is worked on
// at a time; the next one is taken once the result sits in the output
// register, and the output register holds its result while the receiver
// stalls. After reset a clearing pass zeroes the bitmap and item counters,
// one entry a cycle until all are zero; input stall stays high during it.
// recall_capped (capped_q) is written through cfg_we_i/cfg_wdata_i; the user
// must write it only while idle, the block itself does not enforce it.
// Depends on rma_pkg, rma_ctrl, rma_dpath and rma_div.
module ranking_metric_accumulator #(
  parameter int N_ITEMS   = 4096,
  parameter int MAX_LIST  = 64,
  parameter int MAX_TRUTH = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 cmd_i,
  input  logic [rma_pkg::ITEM_W-1:0] item_i,
  input  logic                       cfg_we_i,
  input  logic                       cfg_wdata_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [rma_pkg::CNT_W-1:0]  total_users_o,
  output logic [rma_pkg::CNT_W-1:0]  valid_users_o,
  output logic [rma_pkg::CNT_W-1:0]  hit_users_o,
  output logic [rma_pkg::SUM_W-1:0]  recall_sum_o,
  output logic [rma_pkg::SUM_W-1:0]  precision_sum_o,
  output logic [rma_pkg::SUM_W-1:0]  ndcg_sum_o,
  output logic [rma_pkg::SUM_W-1:0]  map_sum_o,
  output logic [rma_pkg::CNT_W-1:0]  item_count_o,
  output logic [1:0]                 status_o
);

  rma_pkg::ctl_t ctl;
  rma_pkg::sts_t sts;

  rma_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  rma_dpath #(
    .N_ITEMS   (N_ITEMS),
    .MAX_LIST  (MAX_LIST),
    .MAX_TRUTH (MAX_TRUTH)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctl_i           (ctl),
    .sts_o           (sts),
    .cmd_i           (cmd_i),
    .item_i          (item_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .total_users_o   (total_users_o),
    .valid_users_o   (valid_users_o),
    .hit_users_o     (hit_users_o),
    .recall_sum_o    (recall_sum_o),
    .precision_sum_o (precision_sum_o),
    .ndcg_sum_o      (ndcg_sum_o),
    .map_sum_o       (map_sum_o),
    .item_count_o    (item_count_o),
    .status_o        (status_o)
  );

endmodule

// ----- rtl/rma_div.sv -----
// Serial restoring divider with round-half-up, one quotient bit a cycle.
// Uses rma_pkg for operand widths.
module rma_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [rma_pkg::DIV_NW-1:0] num_i,
  input  logic [rma_pkg::DIV_DW-1:0] den_i,
  output logic                       done_o,
  output logic [rma_pkg::DIV_NW-1:0] quot_o
);

  localparam int NW = rma_pkg::DIV_NW;
  localparam int DW = rma_pkg::DIV_DW;
  localparam int CW = $clog2(NW);

  logic          run_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] den_q;
  logic [DW-1:0] rem_q;
  logic [NW-1:0] quo_q;
  logic [DW:0]   rem_sh;
  logic [DW+1:0] diff;
  logic          qbit;

  assign rem_sh = {rem_q, quo_q[NW-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den_q};
  assign qbit   = !diff[DW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(NW - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= num_i + NW'(den_i >> 1);
    end else if (run_q) begin
      rem_q <= qbit ? diff[DW-1:0] : rem_sh[DW-1:0];
      quo_q <= {quo_q[NW-2:0], qbit};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !run_q) else $error("divider started while running");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !run_q) else $error("divider done while still running");
  a_run_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(run_q) |-> $past(start_i)) else $error("divider ran without start");

endmodule

// ----- rtl/rma_ctrl.sv -----
// Sequencer of the ranking metric accumulator: clear pass, item execution,
// truth-list walk and divider schedule. Uses rma_pkg control/status structs.
module rma_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic          out_stall_i,
  output logic          out_valid_o,
  input  rma_pkg::sts_t sts_i,
  output rma_pkg::ctl_t ctl_o
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_EXEC, S_HITW, S_WALK, S_DIVS, S_DIVW, S_FIN
  } state_e;

  state_e         state_q, state_d;
  rma_pkg::dsel_e sel_q, sel_d, sel_nx;
  logic           oval_q, oval_d;

  always_comb begin
    case (sel_q)
      rma_pkg::DS_REC:  sel_nx = rma_pkg::DS_PRE;
      rma_pkg::DS_PRE:  sel_nx = rma_pkg::DS_NDCG;
      default:          sel_nx = rma_pkg::DS_MAP;
    endcase
  end

  always_comb begin
    ctl_o         = '0;
    ctl_o.div_sel = sel_q;
    state_d       = state_q;
    sel_d         = sel_q;
    case (state_q)
      S_CLEAR: begin
        ctl_o.clr_step = 1'b1;
        if (sts_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.accept = 1'b1;
          sel_d        = rma_pkg::DS_HIT;
          state_d      = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl_o.exec = 1'b1;
        if (sts_i.cmd == rma_pkg::CMD_END) begin
          ctl_o.walk_start = 1'b1;
          state_d          = S_WALK;
        end else if (sts_i.hit_fire) begin
          ctl_o.div_start = 1'b1;
          state_d         = S_HITW;
        end else begin
          state_d = S_FIN;
        end
      end
      S_HITW: begin
        if (sts_i.div_done) state_d = S_FIN;
      end
      S_WALK: begin
        ctl_o.walk_step = 1'b1;
        if (sts_i.walk_end) begin
          if (sts_i.empty_user) begin
            ctl_o.user_clear = 1'b1;
            state_d          = S_FIN;
          end else begin
            sel_d   = rma_pkg::DS_REC;
            state_d = S_DIVS;
          end
        end
      end
      S_DIVS: begin
        ctl_o.div_start = 1'b1;
        state_d         = S_DIVW;
      end
      S_DIVW: begin
        if (sts_i.div_done) begin
          if (sel_q == rma_pkg::DS_MAP) begin
            ctl_o.user_clear = 1'b1;
            state_d          = S_FIN;
          end else begin
            sel_d   = sel_nx;
            state_d = S_DIVS;
          end
        end
      end
      S_FIN: begin
        if (!oval_q || !out_stall_i) begin
          ctl_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold the result while the receiver stalls.
  always_comb begin
    if (ctl_o.out_load) oval_d = 1'b1;
    else if (!out_stall_i) oval_d = 1'b0;
    else oval_d = oval_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      sel_q   <= rma_pkg::DS_HIT;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
      oval_q  <= oval_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = oval_q;

endmodule

// ----- rtl/rma_dpath.sv -----
// Datapath of the ranking metric accumulator: truth bitmap, truth list and
// item counter memories, per-user accumulators, sums and output register.
// Uses rma_pkg and instantiates rma_div.
module rma_dpath #(
  parameter int N_ITEMS   = 4096,
  parameter int MAX_LIST  = 64,
  parameter int MAX_TRUTH = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rma_pkg::ctl_t               ctl_i,
  output rma_pkg::sts_t               sts_o,
  input  logic [1:0]                  cmd_i,
  input  logic [rma_pkg::ITEM_W-1:0]  item_i,
  input  logic                        cfg_we_i,
  input  logic                        cfg_wdata_i,
  output logic [rma_pkg::CNT_W-1:0]   total_users_o,
  output logic [rma_pkg::CNT_W-1:0]   valid_users_o,
  output logic [rma_pkg::CNT_W-1:0]   hit_users_o,
  output logic [rma_pkg::SUM_W-1:0]   recall_sum_o,
  output logic [rma_pkg::SUM_W-1:0]   precision_sum_o,
  output logic [rma_pkg::SUM_W-1:0]   ndcg_sum_o,
  output logic [rma_pkg::SUM_W-1:0]   map_sum_o,
  output logic [rma_pkg::CNT_W-1:0]   item_count_o,
  output logic [1:0]                  status_o
);

  localparam int IW  = (N_ITEMS > 1) ? $clog2(N_ITEMS) : 1;
  localparam int TCW = $clog2(MAX_TRUTH + 1);
  localparam int RCW = $clog2(MAX_LIST + 1);
  localparam int LIW = (MAX_TRUTH > 1) ? $clog2(MAX_TRUTH) : 1;
  localparam int DIW = (MAX_LIST > 1) ? $clog2(MAX_LIST) : 1;
  localparam int GW  = rma_pkg::DISC_W + RCW;
  localparam int FW  = rma_pkg::FRAC_W;
  localparam int CW  = rma_pkg::CNT_W;
  localparam int SW  = rma_pkg::SUM_W;
  localparam int NW  = rma_pkg::DIV_NW;
  localparam int DW  = rma_pkg::DIV_DW;
  localparam int XW  = rma_pkg::ITEM_W;

  logic [rma_pkg::DISC_W-1:0] disc_w [MAX_LIST];

  for (genvar g = 0; g < MAX_LIST; g++) begin : g_disc
    localparam logic [rma_pkg::DISC_W-1:0] DV = rma_pkg::disc_calc(32'(g) + 32'd2);
    assign disc_w[g] = DV;
  end

  // memories
  logic          bm_mem   [N_ITEMS];
  logic [CW-1:0] cnt_mem  [N_ITEMS];
  logic [XW-1:0] list_mem [MAX_TRUTH];
  logic          bm_rd_q;
  logic [CW-1:0] cnt_rd_q;
  logic [XW-1:0] list_rd_q;

  // control and per-user state
  rma_pkg::cmd_e cmd_q;
  logic [XW-1:0] item_q;
  logic          capped_q;
  logic [IW-1:0] clr_q;
  logic [TCW-1:0] t_q;
  logic [RCW-1:0] n_q;
  logic [RCW-1:0] hits_q;
  logic [GW-1:0]  gain_q;
  logic [GW-1:0]  pacc_q;
  logic [GW-1:0]  idcg_q;
  logic [TCW-1:0] idx_q;
  logic           pend_q;
  logic [CW-1:0]  tot_q, val_q, hitu_q;
  logic [SW-1:0]  rec_q, pre_q, ndcg_q, map_q;
  logic [CW-1:0]  count_q;
  rma_pkg::status_e status_q;

  logic           in_rng, t_full, n_full, empty;
  logic           ins_truth, bump, hit;
  logic [TCW-1:0] m_w;
  logic [DW-1:0]  d_rec;
  logic [DIW-1:0] rank_ix, walk_ix;
  logic [NW-1:0]  div_num;
  logic [DW-1:0]  div_den;
  logic           div_done;
  logic [NW-1:0]  div_quot;

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
    return (v == '1) ? v : v + CW'(1);
  endfunction

  function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] s, input logic [NW-1:0] v);
    logic [SW:0] r;
    r = {1'b0, s} + (SW + 1)'(v);
    return r[SW] ? '1 : r[SW-1:0];
  endfunction

  assign in_rng  = 32'(item_q) < 32'(N_ITEMS);
  assign t_full  = 32'(t_q) >= 32'(MAX_TRUTH);
  assign n_full  = 32'(n_q) >= 32'(MAX_LIST);
  assign empty   = (t_q == '0) || (n_q == '0);
  assign m_w     = (32'(t_q) < 32'(n_q)) ? t_q : TCW'(n_q);
  assign d_rec   = capped_q ? DW'(m_w) : DW'(t_q);
  assign rank_ix = DIW'(n_q);
  assign walk_ix = DIW'(idx_q);

  assign ins_truth = ctl_i.exec && cmd_q == rma_pkg::CMD_TRUTH && in_rng && !bm_rd_q && !t_full;
  assign bump      = ctl_i.exec && cmd_q == rma_pkg::CMD_REC && in_rng && !n_full;
  assign hit       = cmd_q == rma_pkg::CMD_REC && in_rng && !n_full && bm_rd_q;

  always_comb begin
    case (ctl_i.div_sel)
      rma_pkg::DS_HIT: begin
        div_num = NW'({RCW'(hits_q + RCW'(1)), FW'(0)});
        div_den = DW'(n_q) + DW'(1);
      end
      rma_pkg::DS_REC: begin
        div_num = NW'({hits_q, FW'(0)});
        div_den = d_rec;
      end
      rma_pkg::DS_PRE: begin
        div_num = NW'({hits_q, FW'(0)});
        div_den = DW'(n_q);
      end
      rma_pkg::DS_NDCG: begin
        div_num = NW'({gain_q, FW'(0)});
        div_den = DW'(idcg_q);
      end
      rma_pkg::DS_MAP: begin
        div_num = NW'(pacc_q);
        div_den = DW'(t_q);
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  rma_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctl_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Bitmap: clear pass, walk clear and truth insert share the write port.
  always_ff @(posedge clk_i) begin
    if (ctl_i.clr_step) bm_mem[clr_q] <= 1'b0;
    else if (pend_q) bm_mem[IW'(list_rd_q)] <= 1'b0;
    else if (ins_truth) bm_mem[IW'(item_q)] <= 1'b1;
    if (ctl_i.accept) bm_rd_q <= bm_mem[IW'(item_i)];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.clr_step) cnt_mem[clr_q] <= '0;
    else if (bump) cnt_mem[IW'(item_q)] <= sat_inc(cnt_rd_q);
    if (ctl_i.accept) cnt_rd_q <= cnt_mem[IW'(item_i)];
  end

  always_ff @(posedge clk_i) begin
    if (ins_truth) list_mem[LIW'(t_q)] <= item_q;
    if (ctl_i.walk_step && idx_q != t_q) list_rd_q <= list_mem[LIW'(idx_q)];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      cmd_q  <= rma_pkg::cmd_e'(cmd_i);
      item_q <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capped_q <= 1'b0;
      clr_q    <= '0;
      t_q      <= '0;
      n_q      <= '0;
      hits_q   <= '0;
      gain_q   <= '0;
      pacc_q   <= '0;
      idcg_q   <= '0;
      idx_q    <= '0;
      pend_q   <= 1'b0;
      tot_q    <= '0;
      val_q    <= '0;
      hitu_q   <= '0;
      rec_q    <= '0;
      pre_q    <= '0;
      ndcg_q   <= '0;
      map_q    <= '0;
      count_q  <= '0;
      status_q <= rma_pkg::ST_OK;
    end else begin
      if (cfg_we_i) capped_q <= cfg_wdata_i;
      if (ctl_i.clr_step) clr_q <= clr_q + IW'(1);
      if (ctl_i.accept) begin
        count_q  <= '0;
        status_q <= rma_pkg::ST_OK;
      end
      if (ctl_i.exec) begin
        case (cmd_q)
          rma_pkg::CMD_TRUTH: begin
            if (!in_rng || (t_full && !bm_rd_q)) status_q <= rma_pkg::ST_DROP;
            else if (bm_rd_q) status_q <= rma_pkg::ST_DUP;
            else t_q <= t_q + TCW'(1);
          end
          rma_pkg::CMD_REC: begin
            if (!in_rng || n_full) begin
              status_q <= rma_pkg::ST_DROP;
            end else begin
              n_q <= n_q + RCW'(1);
              if (bm_rd_q) begin
                hits_q <= hits_q + RCW'(1);
                gain_q <= gain_q + GW'(disc_w[rank_ix]);
              end
            end
          end
          rma_pkg::CMD_END: begin
            tot_q <= sat_inc(tot_q);
            if (empty) begin
              status_q <= rma_pkg::ST_COUNTED;
            end else begin
              val_q <= sat_inc(val_q);
              if (hits_q != '0) hitu_q <= sat_inc(hitu_q);
            end
          end
          default: begin
            if (in_rng) count_q <= cnt_rd_q;
            else status_q <= rma_pkg::ST_DROP;
          end
        endcase
      end
      // Walk the truth list: clear its bitmap bits and sum the ideal gain.
      pend_q <= 1'b0;
      if (ctl_i.walk_start) begin
        idx_q  <= '0;
        idcg_q <= '0;
      end else if (ctl_i.walk_step && idx_q != t_q) begin
        idx_q  <= idx_q + TCW'(1);
        pend_q <= 1'b1;
        if (idx_q < m_w) idcg_q <= idcg_q + GW'(disc_w[walk_ix]);
      end
      if (div_done) begin
        case (ctl_i.div_sel)
          rma_pkg::DS_HIT:  pacc_q <= pacc_q + GW'(div_quot);
          rma_pkg::DS_REC:  rec_q  <= sat_add(rec_q, div_quot);
          rma_pkg::DS_PRE:  pre_q  <= sat_add(pre_q, div_quot);
          rma_pkg::DS_NDCG: ndcg_q <= sat_add(ndcg_q, div_quot);
          default:          map_q  <= sat_add(map_q, div_quot);
        endcase
      end
      if (ctl_i.user_clear) begin
        t_q    <= '0;
        n_q    <= '0;
        hits_q <= '0;
        gain_q <= '0;
        pacc_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.out_load) begin
      total_users_o   <= tot_q;
      valid_users_o   <= val_q;
      hit_users_o     <= hitu_q;
      recall_sum_o    <= rec_q;
      precision_sum_o <= pre_q;
      ndcg_sum_o      <= ndcg_q;
      map_sum_o       <= map_q;
      item_count_o    <= count_q;
      status_o        <= status_q;
    end
  end

  assign sts_o.clr_done   = (clr_q == IW'(N_ITEMS - 1));
  assign sts_o.cmd        = cmd_q;
  assign sts_o.hit_fire   = hit;
  assign sts_o.empty_user = empty;
  assign sts_o.walk_end   = (idx_q == t_q) && !pend_q;
  assign sts_o.div_done   = div_done;

endmodule
